// ----- rtl/core/tsb_pkg.sv -----
// shared constants, codes and types of the terminal screen buffer
package tsb_pkg;

    localparam int ROWS_MAX = 64;
    localparam int COLS_MAX = 256;
    localparam int HIST_MAX = 192;
    localparam int CELL_W   = 32;
    localparam int LINE_W   = 8;
    localparam int COL_W    = 8;
    localparam int ADDR_W   = LINE_W + COL_W;

    localparam logic [CELL_W-1:0] CHAR_MASK = 32'h001F_FFFF;
    localparam logic [CELL_W-1:0] BLANK     = 32'h0000_0020;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_HLIM = 2'd2;

    localparam logic [3:0] ACT_WRITE  = 4'd0;
    localparam logic [3:0] ACT_INSERT = 4'd1;
    localparam logic [3:0] ACT_DELETE = 4'd2;
    localparam logic [3:0] ACT_SPAN   = 4'd3;
    localparam logic [3:0] ACT_ROWS   = 4'd4;
    localparam logic [3:0] ACT_SCROLL = 4'd5;
    localparam logic [3:0] ACT_VADJ   = 4'd6;
    localparam logic [3:0] ACT_VSET   = 4'd7;
    localparam logic [3:0] ACT_READ   = 4'd8;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_CELL  = 2'd1,
        KIND_LINES = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        applied;
        logic [7:0]  line_k;
        logic [7:0]  line_end;
        logic        rot;
        logic [7:0]  rot_lo;
        logic [7:0]  rot_hi;
        logic [7:0]  rot_src;
        logic        pre_rd;
        logic [8:0]  cp_cnt;
        logic [7:0]  cp_dst;
        logic [7:0]  cp_src;
        logic        cp_up;
        logic        do_fill;
        logic [7:0]  f_start;
        logic [7:0]  f_end;
        logic [7:0]  new_view;
        logic [7:0]  new_hist;
    } t_plan;

endpackage

// ----- rtl/core/tsb_cmd_if.sv -----
// command channel of the terminal screen buffer
interface tsb_cmd_if;
    logic              valid;
    logic              ready;
    logic [3:0]        action;
    logic [7:0]        row;
    logic [7:0]        row_end;
    logic [8:0]        col;
    logic [8:0]        col_end;
    logic signed [9:0] count;
    logic [31:0]       cell_req;

    modport source (output valid, action, row, row_end, col, col_end, count, cell_req,
                    input ready);
    modport sink (input valid, action, row, row_end, col, col_end, count, cell_req,
                  output ready);
endinterface

// ----- rtl/core/tsb_res_if.sv -----
// result channel of the terminal screen buffer
interface tsb_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] cell_out;
    logic [7:0]  view_offset;
    logic [7:0]  history_count;
    logic        applied;

    modport source (output valid, cell_out, view_offset, history_count, applied,
                    input ready);
    modport sink (input valid, cell_out, view_offset, history_count, applied,
                  output ready);
endinterface

// ----- rtl/core/tsb_decode.sv -----
// command decode: range checks, clamping and the work plan of one command
module tsb_decode
    import tsb_pkg::*;
(
    input  logic [3:0]        i_action,
    input  logic [7:0]        i_row,
    input  logic [7:0]        i_row_end,
    input  logic [8:0]        i_col,
    input  logic [8:0]        i_col_end,
    input  logic signed [9:0] i_count,
    input  logic [6:0]        i_rows,
    input  logic [8:0]        i_cols,
    input  logic [7:0]        i_lim,
    input  logic [7:0]        i_view,
    input  logic [7:0]        i_hist,
    output t_plan             o_plan
);

    logic               pos_ok;
    logic [7:0]         rows8;
    logic [7:0]         k;
    logic [8:0]         last;
    logic [8:0]         rest;
    logic [8:0]         ndel;
    logic [8:0]         cs;
    logic [8:0]         ce;
    logic [7:0]         rs;
    logic [7:0]         re;
    logic [7:0]         ke;
    logic [7:0]         ks;
    logic [6:0]         h;
    logic [9:0]         mag;
    logic [6:0]         nsc;
    logic [7:0]         hi;
    logic [8:0]         len;
    logic [7:0]         off;
    logic [8:0]         hsum;
    logic [8:0]         vsum;
    logic [7:0]         nh;
    logic signed [11:0] vt;
    logic [9:0]         target;
    logic [9:0]         t1;
    logic [8:0]         kv;

    always_comb begin
        rows8  = {1'b0, i_rows};
        pos_ok = (i_row != 8'd0) && (i_row <= rows8) && (i_col != 9'd0) && (i_col <= i_cols);
        k      = rows8 - i_row;
        last   = (i_col_end > i_cols) ? i_cols : i_col_end;
        rest   = i_cols - i_col + 9'd1;
        ndel   = (i_count[9] || (i_count[8:0] > rest)) ? rest : i_count[8:0];
        cs     = (i_col == 9'd0) ? 9'd1 : i_col;
        ce     = (i_col_end > i_cols) ? i_cols : i_col_end;
        rs     = (i_row == 8'd0) ? 8'd1 : i_row;
        re     = (i_row_end > rows8) ? rows8 : i_row_end;
        ke     = rows8 - re;
        ks     = rows8 - rs;
        h      = 7'(re - rs + 8'd1);
        mag    = i_count[9] ? 10'(-{i_count[9], i_count}) : {1'b0, i_count[8:0]};
        nsc    = (mag > {3'd0, h}) ? h : mag[6:0];
        if (!i_count[9]) begin
            hi = (rs == 8'd1) ? 8'd255 : ks;
        end else begin
            hi = ks;
        end
        len = {1'b0, hi} - {1'b0, ke} + 9'd1;
        if ({2'd0, nsc} == len) begin
            off = 8'd0;
        end else if (!i_count[9]) begin
            off = 8'(len - {2'd0, nsc});
        end else begin
            off = {1'b0, nsc};
        end
        hsum = {1'b0, i_hist} + {2'd0, nsc};
        nh   = (hsum > {1'b0, i_lim}) ? i_lim : hsum[7:0];
        vsum = {1'b0, i_view} + {2'd0, nsc};
        // view target before clamping to limit and history
        vt   = $signed({4'd0, i_view}) + 12'(i_count);
        if (i_action == ACT_VSET) begin
            target = i_count[9] ? 10'h3FF : {1'b0, i_count[8:0]};
        end else begin
            target = (vt <= 12'sd0) ? 10'd0 : vt[9:0];
        end
        t1 = (target > {2'd0, i_lim}) ? {2'd0, i_lim} : target;
        kv = {1'b0, k} + {1'b0, i_view};

        o_plan          = '0;
        o_plan.kind     = KIND_NONE;
        o_plan.new_view = i_view;
        o_plan.new_hist = i_hist;
        o_plan.line_k   = k;
        o_plan.line_end = k;
        o_plan.do_fill  = 1'b1;
        o_plan.f_start  = 8'(i_col - 9'd1);
        o_plan.f_end    = 8'(i_col - 9'd1);

        case (i_action)
            ACT_WRITE: begin
                if (pos_ok) begin
                    o_plan.kind    = KIND_CELL;
                    o_plan.applied = 1'b1;
                end
            end
            ACT_INSERT: begin
                if (pos_ok && (i_col <= i_col_end)) begin
                    o_plan.kind    = KIND_CELL;
                    o_plan.applied = 1'b1;
                    o_plan.cp_cnt  = last - i_col;
                    o_plan.cp_dst  = 8'(last - 9'd1);
                    o_plan.cp_src  = 8'(last - 9'd2);
                end
            end
            ACT_DELETE: begin
                if (pos_ok) begin
                    o_plan.kind    = KIND_CELL;
                    o_plan.applied = 1'b1;
                    o_plan.pre_rd  = 1'b1;
                    o_plan.cp_cnt  = rest - ndel;
                    o_plan.cp_dst  = 8'(i_col - 9'd1);
                    o_plan.cp_src  = 8'(i_col - 9'd1 + ndel);
                    o_plan.cp_up   = 1'b1;
                    o_plan.do_fill = (ndel != 9'd0);
                    o_plan.f_start = 8'(i_cols - ndel);
                    o_plan.f_end   = 8'(i_cols - 9'd1);
                end
            end
            ACT_SPAN: begin
                if ((i_row != 8'd0) && (i_row <= rows8) && (i_col <= i_cols)
                    && (i_col_end != 9'd0) && (cs <= ce)) begin
                    o_plan.kind    = KIND_CELL;
                    o_plan.applied = 1'b1;
                    o_plan.f_start = 8'(cs - 9'd1);
                    o_plan.f_end   = 8'(ce - 9'd1);
                end
            end
            ACT_ROWS, ACT_SCROLL: begin
                if ((rs <= re) && !((i_action == ACT_SCROLL) && (i_count == 10'sd0))) begin
                    o_plan.kind    = KIND_LINES;
                    o_plan.applied = 1'b1;
                    o_plan.f_start = 8'd0;
                    o_plan.f_end   = 8'(i_cols - 9'd1);
                    o_plan.line_k  = ke;
                    o_plan.line_end = ks;
                    if (i_action == ACT_SCROLL) begin
                        o_plan.rot     = 1'b1;
                        o_plan.rot_lo  = ke;
                        o_plan.rot_hi  = hi;
                        o_plan.rot_src = ke + off;
                        if (!i_count[9]) begin
                            o_plan.line_end = ke + {1'b0, nsc} - 8'd1;
                            // pushing from the top row feeds the history
                            if (rs == 8'd1) begin
                                o_plan.new_hist = nh;
                                if (i_view != 8'd0) begin
                                    o_plan.new_view = (vsum > {1'b0, nh}) ? nh : vsum[7:0];
                                end
                            end
                        end else begin
                            o_plan.line_k = ks + 8'd1 - {1'b0, nsc};
                        end
                    end
                end
            end
            ACT_VADJ, ACT_VSET: begin
                o_plan.applied  = 1'b1;
                o_plan.new_view = (t1 > {2'd0, i_hist}) ? i_hist : t1[7:0];
            end
            ACT_READ: begin
                if (pos_ok) begin
                    o_plan.applied = 1'b1;
                    o_plan.line_k  = kv[7:0];
                    if (!kv[8]) begin
                        o_plan.kind = KIND_READ;
                    end
                end
            end
            default: begin
                o_plan.applied = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/terminal_screen_buffer.sv -----
// top level: cell store, line map and the command sequencer of the screen buffer
//
//  channel   dir  handshake          payload
//  i_cmd     in   valid/ready        action, row, row_end, col, col_end, count, cell_req
//  o_res     out  valid/ready        cell_out, view_offset, history_count, applied
//  i_cfg_*   in   write enable only  i_cfg_idx, i_cfg_data
//
//  a view or ignored command goes straight to the result; a shift copies cells one by one,
//  row fills go cell by cell per line, and a scroll first rotates the map through a scratch copy.
//  all cell and map traffic goes through one read and one write port per memory.
//  after reset a clearing pass zeroes all 65536 cells of the cell store and loads the map.
//  a finished result waits in the output register while the next command is taken.
module terminal_screen_buffer
    import tsb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsb_cmd_if.sink    i_cmd,
    tsb_res_if.source  o_res,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data
);

    typedef enum logic [15:0] {
        ST_CLR  = 16'h0001,
        ST_IDLE = 16'h0002,
        ST_RCR  = 16'h0004,
        ST_RCW  = 16'h0008,
        ST_RWR  = 16'h0010,
        ST_RWW  = 16'h0020,
        ST_MAPR = 16'h0040,
        ST_MAPW = 16'h0080,
        ST_PRD  = 16'h0100,
        ST_PWT  = 16'h0200,
        ST_CRD  = 16'h0400,
        ST_CWR  = 16'h0800,
        ST_FIL  = 16'h1000,
        ST_RRD  = 16'h2000,
        ST_RWT  = 16'h4000,
        ST_DONE = 16'h8000
    } t_state;

    t_state            r_state;
    logic [6:0]        r_rows;
    logic [8:0]        r_cols;
    logic [7:0]        r_hlim;
    logic [7:0]        r_view;
    logic [7:0]        r_hist;
    logic [ADDR_W-1:0] r_clr;
    t_plan             r_plan;
    logic [CELL_W-1:0] r_fval;
    logic [CELL_W-1:0] r_res;
    logic [7:0]        r_line;
    logic [7:0]        r_lcur;
    logic [7:0]        r_j;
    logic [7:0]        r_src;
    logic [7:0]        r_dst;
    logic [8:0]        r_cnt;
    logic [7:0]        r_fi;
    logic              r_ovalid;
    logic [CELL_W-1:0] r_o_cell;
    logic [7:0]        r_o_view;
    logic [7:0]        r_o_hist;
    logic              r_o_applied;

    logic [CELL_W-1:0] r_cells [0:(1<<ADDR_W)-1];
    logic [7:0]        r_map   [0:(1<<LINE_W)-1];
    logic [7:0]        r_tmp   [0:(1<<LINE_W)-1];
    logic [CELL_W-1:0] r_cell_rd;
    logic [7:0]        r_map_rd;
    logic [7:0]        r_tmp_rd;

    logic [6:0]        rows;
    logic [8:0]        cols;
    logic [7:0]        lim;
    t_plan             plan;

    logic              cell_we;
    logic              cell_re;
    logic [ADDR_W-1:0] cell_waddr;
    logic [ADDR_W-1:0] cell_raddr;
    logic [CELL_W-1:0] cell_wdata;
    logic              map_we;
    logic              map_re;
    logic [7:0]        map_waddr;
    logic [7:0]        map_raddr;
    logic [7:0]        map_wdata;
    logic              tmp_we;
    logic              tmp_re;

    always_comb begin
        if (r_rows == 7'd0) begin
            rows = 7'd1;
        end else if (r_rows > 7'(ROWS_MAX)) begin
            rows = 7'(ROWS_MAX);
        end else begin
            rows = r_rows;
        end
        if (r_cols == 9'd0) begin
            cols = 9'd1;
        end else if (r_cols > 9'(COLS_MAX)) begin
            cols = 9'(COLS_MAX);
        end else begin
            cols = r_cols;
        end
        lim = (r_hlim > 8'(HIST_MAX)) ? 8'(HIST_MAX) : r_hlim;
    end

    tsb_decode u_decode (
        .i_action  (i_cmd.action),
        .i_row     (i_cmd.row),
        .i_row_end (i_cmd.row_end),
        .i_col     (i_cmd.col),
        .i_col_end (i_cmd.col_end),
        .i_count   (i_cmd.count),
        .i_rows    (rows),
        .i_cols    (cols),
        .i_lim     (lim),
        .i_view    (r_view),
        .i_hist    (r_hist),
        .o_plan    (plan)
    );

    assign i_cmd.ready         = (r_state == ST_IDLE);
    assign o_res.valid         = r_ovalid;
    assign o_res.cell_out      = r_o_cell;
    assign o_res.view_offset   = r_o_view;
    assign o_res.history_count = r_o_hist;
    assign o_res.applied       = r_o_applied;

    // memory port steering
    always_comb begin
        cell_we    = 1'b0;
        cell_re    = 1'b0;
        cell_waddr = {r_line, r_fi};
        cell_raddr = {r_line, r_src};
        cell_wdata = r_fval;
        map_we     = 1'b0;
        map_re     = 1'b0;
        map_waddr  = r_j;
        map_raddr  = r_lcur;
        map_wdata  = r_tmp_rd;
        tmp_we     = 1'b0;
        tmp_re     = 1'b0;
        case (r_state)
            ST_CLR: begin
                cell_we    = 1'b1;
                cell_waddr = r_clr;
                cell_wdata = '0;
                map_we     = (r_clr[ADDR_W-1:COL_W] == '0);
                map_waddr  = r_clr[7:0];
                map_wdata  = r_clr[7:0];
            end
            ST_RCR: begin
                map_re    = 1'b1;
                map_raddr = r_j;
            end
            ST_RCW:  tmp_we = 1'b1;
            ST_RWR:  tmp_re = 1'b1;
            ST_RWW:  map_we = 1'b1;
            ST_MAPR: map_re = 1'b1;
            ST_PRD: begin
                cell_re    = 1'b1;
                cell_raddr = {r_line, 8'(cols - 9'd1)};
            end
            ST_CRD:  cell_re = 1'b1;
            ST_CWR: begin
                cell_we    = 1'b1;
                cell_waddr = {r_line, r_dst};
                cell_wdata = r_cell_rd;
            end
            ST_FIL:  cell_we = 1'b1;
            ST_RRD: begin
                cell_re    = 1'b1;
                cell_raddr = {r_line, r_fi};
            end
            default: begin
                cell_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cells[cell_waddr] <= cell_wdata;
        end
        if (cell_re) begin
            r_cell_rd <= r_cells[cell_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            r_map_rd <= r_map[map_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tmp_we) begin
            r_tmp[r_j] <= r_map_rd;
        end
        if (tmp_re) begin
            r_tmp_rd <= r_tmp[r_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_view   <= 8'd0;
            r_hist   <= 8'd0;
            r_rows   <= 7'd24;
            r_cols   <= 9'd80;
            r_hlim   <= 8'd192;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROWS: r_rows <= i_cfg_data[6:0];
                    REG_COLS: r_cols <= i_cfg_data;
                    REG_HLIM: r_hlim <= i_cfg_data[7:0];
                    default:  r_rows <= r_rows;
                endcase
            end
            if ((r_state == ST_DONE) && (!r_ovalid || o_res.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_cmd.valid) begin
                        r_plan <= plan;
                        r_fval <= i_cmd.cell_req;
                        r_res  <= '0;
                        r_view <= plan.new_view;
                        r_hist <= plan.new_hist;
                        r_fi   <= plan.f_start;
                        r_lcur <= plan.line_k;
                        r_j    <= plan.rot_lo;
                        r_src  <= plan.rot ? plan.rot_src : plan.cp_src;
                        r_dst  <= plan.cp_dst;
                        r_cnt  <= plan.cp_cnt;
                        if (plan.kind == KIND_NONE) begin
                            r_state <= ST_DONE;
                        end else if (plan.rot) begin
                            r_state <= ST_RCR;
                        end else begin
                            r_state <= ST_MAPR;
                        end
                    end
                end
                ST_RCR: r_state <= ST_RCW;
                ST_RCW: begin
                    if (r_j == r_plan.rot_hi) begin
                        r_j     <= r_plan.rot_lo;
                        r_state <= ST_RWR;
                    end else begin
                        r_j     <= r_j + 8'd1;
                        r_state <= ST_RCR;
                    end
                end
                ST_RWR: r_state <= ST_RWW;
                ST_RWW: begin
                    // source walks the region with wrap
                    r_src <= (r_src == r_plan.rot_hi) ? r_plan.rot_lo : r_src + 8'd1;
                    if (r_j == r_plan.rot_hi) begin
                        r_state <= ST_MAPR;
                    end else begin
                        r_j     <= r_j + 8'd1;
                        r_state <= ST_RWR;
                    end
                end
                ST_MAPR: r_state <= ST_MAPW;
                ST_MAPW: begin
                    r_line <= r_map_rd;
                    if (r_plan.kind == KIND_READ) begin
                        r_state <= ST_RRD;
                    end else if (r_plan.kind == KIND_LINES) begin
                        r_state <= ST_FIL;
                    end else if (r_plan.pre_rd) begin
                        r_state <= ST_PRD;
                    end else if (r_cnt != 9'd0) begin
                        r_state <= ST_CRD;
                    end else begin
                        r_state <= r_plan.do_fill ? ST_FIL : ST_DONE;
                    end
                end
                ST_PRD: r_state <= ST_PWT;
                ST_PWT: begin
                    // blank keeps the attributes of the last cell
                    r_fval <= (r_cell_rd & ~CHAR_MASK) | BLANK;
                    if (r_cnt != 9'd0) begin
                        r_state <= ST_CRD;
                    end else begin
                        r_state <= r_plan.do_fill ? ST_FIL : ST_DONE;
                    end
                end
                ST_CRD: r_state <= ST_CWR;
                ST_CWR: begin
                    r_cnt <= r_cnt - 9'd1;
                    if (r_plan.cp_up) begin
                        r_dst <= r_dst + 8'd1;
                        r_src <= r_src + 8'd1;
                    end else begin
                        r_dst <= r_dst - 8'd1;
                        r_src <= r_src - 8'd1;
                    end
                    if (r_cnt == 9'd1) begin
                        r_state <= r_plan.do_fill ? ST_FIL : ST_DONE;
                    end else begin
                        r_state <= ST_CRD;
                    end
                end
                ST_FIL: begin
                    if (r_fi == r_plan.f_end) begin
                        if ((r_plan.kind == KIND_LINES) && (r_lcur != r_plan.line_end)) begin
                            r_lcur  <= r_lcur + 8'd1;
                            r_fi    <= r_plan.f_start;
                            r_state <= ST_MAPR;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_fi <= r_fi + 8'd1;
                    end
                end
                ST_RRD: r_state <= ST_RWT;
                ST_RWT: begin
                    r_res   <= r_cell_rd;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_o_cell    <= r_res;
                        r_o_view    <= r_view;
                        r_o_hist    <= r_hist;
                        r_o_applied <= r_plan.applied;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state != ST_IDLE))
        else $error("accepted beat did not start work");
    a_copy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CRD) |-> (r_cnt != 9'd0))
        else $error("cell copy entered with nothing to copy");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIL) |-> (r_fi <= r_plan.f_end))
        else $error("fill index ran past span end");
    a_hist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hist <= 8'(HIST_MAX))
        else $error("history count above maximum");
    a_view_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_view <= r_hist)
        else $error("view offset beyond history");
`endif

endmodule
